### rtl/bsh_pkg.sv
package bsh_pkg;

  localparam int LaneW = 64;
  localparam int ByteW = 8;
  localparam int PosW = 5;
  localparam int StepW = 4;
  localparam int QueuePtrW = 2;
  localparam int QueueDepth = 1 << QueuePtrW;
  localparam int QueueCntW = QueuePtrW + 1;

  localparam logic [LaneW-1:0] GoldenRatio = 64'h9e3779b97f4a7c13;
  localparam logic [PosW-1:0] BlockLastPos = 5'd23;
  localparam logic [StepW-1:0] MixLastStep = 4'd11;

  localparam logic [1:0] LaneSelA = 2'd0;
  localparam logic [1:0] LaneSelB = 2'd1;
  localparam logic [1:0] LaneSelC = 2'd2;

  typedef struct packed {
    logic [LaneW-1:0] seed;
    logic [LaneW-1:0] word_a;
    logic [LaneW-1:0] word_b;
    logic [LaneW-1:0] word_c;
    logic [LaneW-1:0] key_len;
    logic             first;
    logic             blk;
    logic             fin;
  } cmd_t;

endpackage

### rtl/byte_stream_hash64.sv
// Streaming 64-bit key hash. Key bytes enter one per transfer on the input
// queue port (push/full) with has_byte and last; an item with has_byte low
// and last high ends an empty key, and one with both low is ignored. The
// hash of a key leaves on the result queue port (empty/pop) as hash_value.
// The seed is written on the cfg_valid/cfg_ready channel; cfg_ready is
// always high, and a write taken before the first byte of a key seeds that
// key, otherwise the next one.
// The front packs bytes into 24-byte blocks at one byte per cycle while
// the queue is not full, and hands blocks and key ends to the back through
// a four-entry command queue. The back loads a command and mixes it with
// one row per cycle; a key end then goes to a done state that registers
// the result, and a key ending on a block edge first adds the length in a
// tail step and mixes again. Long keys stream at one byte per cycle while
// the queue is not full; short keys are limited by the mixing unit.
// While a result waits unread the back holds the next finished hash and the
// queue keeps accepting until full; full then holds off the sender.
// Reset empties the queue and the result port and clears the seed to zero.
module byte_stream_hash64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  bsh_pkg::cmd_t cmd_in;
  bsh_pkg::cmd_t cmd_out;
  logic          cmd_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  bsh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push),
    .q_full    (q_full)
  );

  bsh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (cmd_out),
    .empty   (q_empty)
  );

  bsh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .hash_value (hash_value),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

### rtl/bsh_front.sv
module bsh_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              data_byte,
  input  logic                    has_byte,
  input  logic                    last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [63:0]             cfg_data,
  output bsh_pkg::cmd_t           cmd,
  output logic                    cmd_push,
  input  logic                    q_full
);

  logic [bsh_pkg::LaneW-1:0] initial_level;
  logic [bsh_pkg::LaneW-1:0] seed;
  logic [bsh_pkg::LaneW-1:0] word_a;
  logic [bsh_pkg::LaneW-1:0] word_b;
  logic [bsh_pkg::LaneW-1:0] word_c;
  logic [bsh_pkg::LaneW-1:0] word_a_next;
  logic [bsh_pkg::LaneW-1:0] word_b_next;
  logic [bsh_pkg::LaneW-1:0] word_c_next;
  logic [bsh_pkg::LaneW-1:0] key_len;
  logic [bsh_pkg::LaneW-1:0] key_len_next;
  logic [bsh_pkg::PosW-1:0]  pos;
  logic                      first_pending;
  logic                      accept;
  logic                      block_done;
  logic [5:0]                slot;

  assign full = q_full;
  assign cfg_ready = 1'b1;
  assign accept = push && !q_full;
  assign block_done = has_byte && (pos == bsh_pkg::BlockLastPos);
  assign key_len_next = key_len + {{(bsh_pkg::LaneW-1){1'b0}}, has_byte};
  assign slot = {pos[2:0], 3'b000};

  always_comb begin
    word_a_next = word_a;
    word_b_next = word_b;
    word_c_next = word_c;
    if (has_byte) begin
      case (pos[4:3])
        bsh_pkg::LaneSelA: word_a_next[slot +: bsh_pkg::ByteW] = data_byte;
        bsh_pkg::LaneSelB: word_b_next[slot +: bsh_pkg::ByteW] = data_byte;
        bsh_pkg::LaneSelC: word_c_next[slot +: bsh_pkg::ByteW] = data_byte;
        default: ;
      endcase
    end
  end

  assign cmd_push = accept && (block_done || last);

  always_comb begin
    cmd.seed    = (key_len == '0) ? initial_level : seed;
    cmd.word_a  = word_a_next;
    cmd.word_b  = word_b_next;
    cmd.word_c  = word_c_next;
    cmd.key_len = key_len_next;
    cmd.first   = first_pending;
    cmd.blk     = block_done;
    cmd.fin     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_level <= '0;
      word_a        <= '0;
      word_b        <= '0;
      word_c        <= '0;
      key_len       <= '0;
      pos           <= '0;
      first_pending <= 1'b1;
    end else begin
      if (cfg_valid) begin
        initial_level <= cfg_data;
      end
      if (accept) begin
        if (cmd_push) begin
          word_a        <= '0;
          word_b        <= '0;
          word_c        <= '0;
          first_pending <= last;
        end else begin
          word_a <= word_a_next;
          word_b <= word_b_next;
          word_c <= word_c_next;
        end
        if (block_done || last) begin
          pos <= '0;
        end else if (has_byte) begin
          pos <= pos + 1'b1;
        end
        key_len <= last ? '0 : key_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_len == '0) begin
      seed <= initial_level;
    end
  end

endmodule

### rtl/bsh_fifo.sv
module bsh_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  bsh_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd,
  output bsh_pkg::cmd_t rd_data,
  output logic          empty
);

  bsh_pkg::cmd_t                 slots [bsh_pkg::QueueDepth];
  logic [bsh_pkg::QueuePtrW-1:0] wr_ptr;
  logic [bsh_pkg::QueuePtrW-1:0] rd_ptr;
  logic [bsh_pkg::QueueCntW-1:0] count;
  logic                          do_wr;
  logic                          do_rd;

  assign full = (count == bsh_pkg::QueueCntW'(bsh_pkg::QueueDepth));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/bsh_back.sv
module bsh_back (
  input  logic          clk,
  input  logic          rst,
  input  bsh_pkg::cmd_t cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic [63:0]   hash_value,
  output logic          empty,
  input  logic          pop
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                     state;
  logic [bsh_pkg::StepW-1:0]  step;
  logic                       fin;
  logic                       tail;
  logic                       out_valid;
  logic                       out_valid_next;
  logic                       out_free;
  logic                       out_load;
  logic [bsh_pkg::LaneW-1:0]  lane_a;
  logic [bsh_pkg::LaneW-1:0]  lane_b;
  logic [bsh_pkg::LaneW-1:0]  lane_c;
  logic [bsh_pkg::LaneW-1:0]  key_len;
  logic [bsh_pkg::LaneW-1:0]  mix_a;
  logic [bsh_pkg::LaneW-1:0]  mix_b;
  logic [bsh_pkg::LaneW-1:0]  mix_c;
  logic [bsh_pkg::LaneW-1:0]  base_a;
  logic [bsh_pkg::LaneW-1:0]  base_b;
  logic [bsh_pkg::LaneW-1:0]  base_c;
  logic [bsh_pkg::LaneW-1:0]  add_c;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign out_load = (state == ST_DONE) && out_free;
  assign out_valid_next = out_load ? 1'b1 : (out_valid && !pop);
  assign empty = !out_valid;

  // One row of the mixing function per cycle; each row sees the rows before it.
  always_comb begin
    mix_a = lane_a;
    mix_b = lane_b;
    mix_c = lane_c;
    unique case (step)
      4'd0:    mix_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 43);
      4'd1:    mix_b = (lane_b - lane_c - lane_a) ^ (lane_a << 9);
      4'd2:    mix_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 8);
      4'd3:    mix_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 38);
      4'd4:    mix_b = (lane_b - lane_c - lane_a) ^ (lane_a << 23);
      4'd5:    mix_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 5);
      4'd6:    mix_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 35);
      4'd7:    mix_b = (lane_b - lane_c - lane_a) ^ (lane_a << 49);
      4'd8:    mix_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 11);
      4'd9:    mix_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 12);
      4'd10:   mix_b = (lane_b - lane_c - lane_a) ^ (lane_a << 18);
      4'd11:   mix_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 22);
      default: ;
    endcase
  end

  always_comb begin
    base_a = cmd.first ? cmd.seed : lane_a;
    base_b = cmd.first ? cmd.seed : lane_b;
    base_c = cmd.first ? bsh_pkg::GoldenRatio : lane_c;
    add_c  = cmd.blk ? cmd.word_c : (cmd.key_len + (cmd.word_c << 8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      fin       <= 1'b0;
      tail      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            fin   <= cmd.fin;
            tail  <= cmd.blk && cmd.fin;
            step  <= '0;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (step == bsh_pkg::MixLastStep) begin
            step <= '0;
            if (tail) begin
              state <= ST_TAIL;
            end else if (fin) begin
              state <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_TAIL: begin
          tail  <= 1'b0;
          state <= ST_MIX;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          lane_a  <= base_a + cmd.word_a;
          lane_b  <= base_b + cmd.word_b;
          lane_c  <= base_c + add_c;
          key_len <= cmd.key_len;
        end
      end
      ST_MIX: begin
        lane_a <= mix_a;
        lane_b <= mix_b;
        lane_c <= mix_c;
      end
      ST_TAIL: lane_c <= lane_c + key_len;
      ST_DONE: begin
        if (out_free) begin
          hash_value <= lane_c;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/bsh_checker.sv
module bsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic [7:0]  data_byte,
  input logic        has_byte,
  input logic        last,
  input logic        empty,
  input logic        pop,
  input logic [63:0] hash_value,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [63:0] cfg_data
);

  // After reset the result port is empty and the input side is not full.
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not clear after reset");

  // A waiting result is held while the receiver stalls.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hash_value)))
    else $error("result changed while stalled");

  // The input side fills only through transfers.
  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transfer");

  // The seed channel never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind byte_stream_hash64 bsh_checker u_bsh_checker (.*);
